[design/cwwe_pkg.sv]
// shared types, codes and widths for the counter wait/wake engine
// used by cwwe_ctrl, cwwe_dpath and counter_wait_wake_engine; no dependencies

package cwwe_pkg;

   localparam int NUM_COUNTERS_DEF = 16;
   localparam int MAX_WAITERS_DEF  = 8;
   localparam int NUM_FIBERS_DEF   = 64;

   localparam int ACTION_W = 2;
   localparam int CID_W    = 4;
   localparam int FIBER_W  = 6;
   localparam int VAL_W    = 16;
   localparam int STATUS_W = 2;

   localparam logic [VAL_W-1:0] VAL_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD    = 2'd0,
      ACT_SIGNAL = 2'd1,
      ACT_PARK   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_UNDER = 2'd2,
      ST_OVER  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FLUSH
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic scan_rd;
      logic scan_chk;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic scan_go;
      logic chk_stall;
      logic scan_last;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [FIBER_W-1:0] fiber;
      logic [VAL_W-1:0]   target;
   } waiter_type;

endpackage

[design/counter_wait_wake_engine.sv]
// Counter wait/wake engine: a table of NUM_COUNTERS job counters, each with an ordered
// list of up to MAX_WAITERS parked fibers kept in a single-port-write, registered-read
// waiter memory. One request is worked at a time. Add, park, signal on an empty list and
// unused or out-of-range requests go through accept, decide and respond; signal on a
// non-empty list adds a memory read step and a compare/compact step per parked entry
// before respond. The final response shows up the cycle after the respond cycle, the same
// cycle the next request can be accepted. Any cycle that loads the response register (the
// second and later woken fibers, and the final response) holds while the previous
// response is still waiting on the response side.
// Counter state needs no clearing pass; a valid bit per counter makes unwritten counters
// read as zero right after reset.
// Depends on cwwe_pkg, cwwe_ctrl and cwwe_dpath.

module counter_wait_wake_engine #(
   parameter int NUM_COUNTERS = cwwe_pkg::NUM_COUNTERS_DEF,
   parameter int MAX_WAITERS  = cwwe_pkg::MAX_WAITERS_DEF,
   parameter int NUM_FIBERS   = cwwe_pkg::NUM_FIBERS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cwwe_pkg::ACTION_W-1:0] req_action,
   input  logic [cwwe_pkg::CID_W-1:0]    req_counter_id,
   input  logic [cwwe_pkg::FIBER_W-1:0]  req_fiber_id,
   input  logic [cwwe_pkg::VAL_W-1:0]    req_target,
   input  logic [cwwe_pkg::VAL_W-1:0]    req_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_woke,
   output logic [cwwe_pkg::FIBER_W-1:0]  rsp_ready_fiber,
   output logic [cwwe_pkg::VAL_W-1:0]    rsp_counter_value,
   output logic [cwwe_pkg::STATUS_W-1:0] rsp_status,
   output logic                          rsp_last
);

   cwwe_pkg::ctl_cmd_type   ctl_cmd;
   cwwe_pkg::dp_status_type dp_stat;

   cwwe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .ctl_cmd   (ctl_cmd)
   );

   cwwe_dpath #(
      .NUM_COUNTERS (NUM_COUNTERS),
      .MAX_WAITERS  (MAX_WAITERS),
      .NUM_FIBERS   (NUM_FIBERS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctl_cmd           (ctl_cmd),
      .dp_stat           (dp_stat),
      .req_action        (req_action),
      .req_counter_id    (req_counter_id),
      .req_fiber_id      (req_fiber_id),
      .req_target        (req_target),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_woke          (rsp_woke),
      .rsp_ready_fiber   (rsp_ready_fiber),
      .rsp_counter_value (rsp_counter_value),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   // a request is worked alone
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in progress");

   a_idle_fiber_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_woke |-> rsp_ready_fiber == '0)
      else $error("fiber reported without a wake");

   a_over_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cwwe_pkg::ST_OVER |->
      rsp_counter_value == cwwe_pkg::VAL_MAX && rsp_last && !rsp_woke)
      else $error("overflow response without saturated counter");

   a_full_no_wake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cwwe_pkg::ST_FULL |-> !rsp_woke && rsp_last)
      else $error("full list response names a fiber");

   a_under_holds_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cwwe_pkg::ST_UNDER |-> rsp_counter_value == '0)
      else $error("underflow response with nonzero counter");

endmodule

[design/cwwe_ctrl.sv]
// sequencing state machine for the counter wait/wake engine
// depends on cwwe_pkg; drives cwwe_dpath through command and status structs

module cwwe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cwwe_pkg::dp_status_type dp_stat,
   output cwwe_pkg::ctl_cmd_type   ctl_cmd
);

   cwwe_pkg::ctl_state_type state_ff;
   cwwe_pkg::ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwwe_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctl_cmd   = '0;
      req_ready = 1'b0;
      case (state_ff)
         cwwe_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_cmd.load = 1'b1;
               state_in     = cwwe_pkg::S_DECIDE;
            end
         end
         cwwe_pkg::S_DECIDE: begin
            ctl_cmd.decide = 1'b1;
            state_in = dp_stat.scan_go ? cwwe_pkg::S_SCAN_RD : cwwe_pkg::S_FLUSH;
         end
         cwwe_pkg::S_SCAN_RD: begin
            ctl_cmd.scan_rd = 1'b1;
            state_in        = cwwe_pkg::S_SCAN_CHK;
         end
         cwwe_pkg::S_SCAN_CHK: begin
            ctl_cmd.scan_chk = 1'b1;
            if (!dp_stat.chk_stall) begin
               state_in = dp_stat.scan_last ? cwwe_pkg::S_FLUSH : cwwe_pkg::S_SCAN_RD;
            end
         end
         cwwe_pkg::S_FLUSH: begin
            ctl_cmd.flush = 1'b1;
            if (dp_stat.out_free) begin
               state_in = cwwe_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cwwe_pkg::S_IDLE;
         end
      endcase
   end

endmodule

[design/cwwe_dpath.sv]
// counter table, waiter list memory, scan registers and result register
// depends on cwwe_pkg; commanded by cwwe_ctrl

module cwwe_dpath #(
   parameter int NUM_COUNTERS = cwwe_pkg::NUM_COUNTERS_DEF,
   parameter int MAX_WAITERS  = cwwe_pkg::MAX_WAITERS_DEF,
   parameter int NUM_FIBERS   = cwwe_pkg::NUM_FIBERS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cwwe_pkg::ctl_cmd_type               ctl_cmd,
   output cwwe_pkg::dp_status_type             dp_stat,
   input  logic [cwwe_pkg::ACTION_W-1:0]       req_action,
   input  logic [cwwe_pkg::CID_W-1:0]          req_counter_id,
   input  logic [cwwe_pkg::FIBER_W-1:0]        req_fiber_id,
   input  logic [cwwe_pkg::VAL_W-1:0]          req_target,
   input  logic [cwwe_pkg::VAL_W-1:0]          req_amount,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_woke,
   output logic [cwwe_pkg::FIBER_W-1:0]        rsp_ready_fiber,
   output logic [cwwe_pkg::VAL_W-1:0]          rsp_counter_value,
   output logic [cwwe_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                rsp_last
);

   localparam int VAL_W   = cwwe_pkg::VAL_W;
   localparam int FIBER_W = cwwe_pkg::FIBER_W;
   localparam int CID_W   = cwwe_pkg::CID_W;
   localparam int CIDX_W  = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
   localparam int CCMP_W  = ($clog2(NUM_COUNTERS + 1) > CID_W) ?
                            $clog2(NUM_COUNTERS + 1) : CID_W;
   localparam int FCMP_W  = ($clog2(NUM_FIBERS + 1) > FIBER_W) ?
                            $clog2(NUM_FIBERS + 1) : FIBER_W;
   localparam int WCNT_W  = $clog2(MAX_WAITERS + 1);
   localparam int WDEPTH  = NUM_COUNTERS * MAX_WAITERS;
   localparam int WADDR_W = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
   localparam int CWORD_W = VAL_W + WCNT_W;

   // memories
   logic [CWORD_W-1:0]   cnt_mem [NUM_COUNTERS];
   cwwe_pkg::waiter_type wait_mem [WDEPTH];

   // request registers
   cwwe_pkg::action_type act_ff, act_in;
   logic                 in_range_ff, in_range_in;
   logic                 fib_ok_ff, fib_ok_in;
   logic [FIBER_W-1:0]   fiber_ff, fiber_in;
   logic [VAL_W-1:0]     target_ff, target_in;
   logic [VAL_W-1:0]     amount_ff, amount_in;
   logic [CIDX_W-1:0]    cidx_ff, cidx_in;
   logic [WADDR_W-1:0]   base_ff, base_in;

   // counter lookup
   logic [NUM_COUNTERS-1:0] cvalid_ff, cvalid_in;
   logic                    cvld_rd_ff, cvld_rd_in;
   logic [CWORD_W-1:0]      crd_ff;
   logic [CIDX_W-1:0]       req_cidx;
   logic                    cnt_we;

   // working registers
   logic [VAL_W-1:0]     value_ff, value_in;
   cwwe_pkg::status_type status_ff, status_in;
   logic [WCNT_W-1:0]    cnt_ff, cnt_in;
   logic [WCNT_W-1:0]    n_ff, n_in;
   logic [WCNT_W-1:0]    idx_ff, idx_in;
   logic                 wb_ff, wb_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [FIBER_W-1:0]   pend_fiber_ff, pend_fiber_in;
   cwwe_pkg::waiter_type wrd_ff;

   // waiter write port
   logic                 wm_we;
   logic [WADDR_W-1:0]   wm_addr;
   cwwe_pkg::waiter_type wm_wdata;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_woke_ff, rsp_woke_in;
   logic [FIBER_W-1:0]   rsp_fiber_ff, rsp_fiber_in;
   logic [VAL_W-1:0]     rsp_value_ff, rsp_value_in;
   cwwe_pkg::status_type rsp_status_ff, rsp_status_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [VAL_W-1:0]  cur_val;
   logic [WCNT_W-1:0] cur_n;
   logic [VAL_W:0]    sum;
   logic              wake;
   logic              out_free;
   logic              emit;
   logic              fin;

   assign req_cidx = CIDX_W'(req_counter_id);
   assign cur_val  = cvld_rd_ff ? crd_ff[CWORD_W-1 -: VAL_W] : '0;
   assign cur_n    = cvld_rd_ff ? crd_ff[WCNT_W-1:0] : '0;
   assign sum      = {1'b0, cur_val} + {1'b0, amount_ff};
   assign wake     = (value_ff <= wrd_ff.target);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign dp_stat.scan_go   = in_range_ff && (act_ff == cwwe_pkg::ACT_SIGNAL) &&
                              (cur_n != '0);
   assign dp_stat.chk_stall = wake && pend_valid_ff && !out_free;
   assign dp_stat.scan_last = ((idx_ff + WCNT_W'(1)) == n_ff);
   assign dp_stat.out_free  = out_free;

   // request capture
   always_comb begin
      act_in      = act_ff;
      in_range_in = in_range_ff;
      fib_ok_in   = fib_ok_ff;
      fiber_in    = fiber_ff;
      target_in   = target_ff;
      amount_in   = amount_ff;
      cidx_in     = cidx_ff;
      base_in     = base_ff;
      cvld_rd_in  = cvld_rd_ff;
      if (ctl_cmd.load) begin
         act_in      = cwwe_pkg::action_type'(req_action);
         in_range_in = (CCMP_W'(req_counter_id) < CCMP_W'(NUM_COUNTERS));
         fib_ok_in   = (FCMP_W'(req_fiber_id) < FCMP_W'(NUM_FIBERS));
         fiber_in    = req_fiber_id;
         target_in   = req_target;
         amount_in   = req_amount;
         cidx_in     = req_cidx;
         base_in     = WADDR_W'(req_cidx) * WADDR_W'(MAX_WAITERS);
         cvld_rd_in  = in_range_in && cvalid_ff[req_cidx];
      end
   end

   // decide, scan and result
   always_comb begin
      value_in      = value_ff;
      status_in     = status_ff;
      cnt_in        = cnt_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      wb_in         = wb_ff;
      pend_valid_in = pend_valid_ff;
      pend_fiber_in = pend_fiber_ff;
      wm_we         = 1'b0;
      wm_addr       = base_ff + WADDR_W'(cnt_ff);
      wm_wdata      = wrd_ff;
      emit          = 1'b0;
      fin           = 1'b0;
      cnt_we        = 1'b0;

      if (ctl_cmd.load) begin
         pend_valid_in = 1'b0;
         wb_in         = 1'b0;
      end

      if (ctl_cmd.decide) begin
         value_in  = cur_val;
         status_in = cwwe_pkg::ST_OK;
         cnt_in    = cur_n;
         n_in      = cur_n;
         idx_in    = '0;
         wb_in     = 1'b0;
         if (!in_range_ff) begin
            value_in = '0;
         end else begin
            case (act_ff)
               cwwe_pkg::ACT_ADD: begin
                  wb_in = 1'b1;
                  if (sum[VAL_W]) begin
                     value_in  = cwwe_pkg::VAL_MAX;
                     status_in = cwwe_pkg::ST_OVER;
                  end else begin
                     value_in = sum[VAL_W-1:0];
                  end
               end
               cwwe_pkg::ACT_SIGNAL: begin
                  wb_in  = 1'b1;
                  cnt_in = '0;
                  if (cur_val == '0) begin
                     status_in = cwwe_pkg::ST_UNDER;
                  end else begin
                     value_in = cur_val - VAL_W'(1);
                  end
               end
               cwwe_pkg::ACT_PARK: begin
                  if (fib_ok_ff) begin
                     if (cur_val <= target_ff) begin
                        pend_valid_in = 1'b1;
                        pend_fiber_in = fiber_ff;
                     end else if (cur_n == WCNT_W'(MAX_WAITERS)) begin
                        status_in = cwwe_pkg::ST_FULL;
                     end else begin
                        wm_we           = 1'b1;
                        wm_addr         = base_ff + WADDR_W'(cur_n);
                        wm_wdata.fiber  = fiber_ff;
                        wm_wdata.target = target_ff;
                        cnt_in          = cur_n + WCNT_W'(1);
                        wb_in           = 1'b1;
                     end
                  end
               end
               cwwe_pkg::ACT_NONE: begin
                  wb_in = 1'b0;
               end
               default: begin
                  wb_in = 1'b0;
               end
            endcase
         end
      end

      if (ctl_cmd.scan_chk && !dp_stat.chk_stall) begin
         idx_in = idx_ff + WCNT_W'(1);
         if (wake) begin
            emit          = pend_valid_ff;
            pend_valid_in = 1'b1;
            pend_fiber_in = wrd_ff.fiber;
         end else begin
            wm_we  = 1'b1;
            cnt_in = cnt_ff + WCNT_W'(1);
         end
      end

      if (ctl_cmd.flush && out_free) begin
         emit   = 1'b1;
         fin    = 1'b1;
         cnt_we = wb_ff;
      end
   end

   // result register
   always_comb begin
      rsp_woke_in   = rsp_woke_ff;
      rsp_fiber_in  = rsp_fiber_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_woke_in   = fin ? pend_valid_ff : 1'b1;
         rsp_fiber_in  = pend_valid_ff ? pend_fiber_ff : '0;
         rsp_value_in  = value_ff;
         rsp_status_in = status_ff;
         rsp_last_in   = fin;
      end
   end

   always_comb begin
      cvalid_in = cvalid_ff;
      if (cnt_we) begin
         cvalid_in[cidx_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         cvalid_ff     <= '0;
         pend_valid_ff <= 1'b0;
         cvld_rd_ff    <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         cvalid_ff     <= cvalid_in;
         pend_valid_ff <= pend_valid_in;
         cvld_rd_ff    <= cvld_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      in_range_ff   <= in_range_in;
      fib_ok_ff     <= fib_ok_in;
      fiber_ff      <= fiber_in;
      target_ff     <= target_in;
      amount_ff     <= amount_in;
      cidx_ff       <= cidx_in;
      base_ff       <= base_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      cnt_ff        <= cnt_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      wb_ff         <= wb_in;
      pend_fiber_ff <= pend_fiber_in;
      rsp_woke_ff   <= rsp_woke_in;
      rsp_fiber_ff  <= rsp_fiber_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // counter table
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         crd_ff <= cnt_mem[req_cidx];
      end
      if (cnt_we) begin
         cnt_mem[cidx_ff] <= {value_ff, cnt_ff};
      end
   end

   // waiter lists
   always_ff @(posedge clock) begin
      if (ctl_cmd.scan_rd) begin
         wrd_ff <= wait_mem[base_ff + WADDR_W'(idx_ff)];
      end
      if (wm_we) begin
         wait_mem[wm_addr] <= wm_wdata;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_woke          = rsp_woke_ff;
   assign rsp_ready_fiber   = rsp_fiber_ff;
   assign rsp_counter_value = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

[dv/counter_wait_wake_engine_test.sv]
// self-checking testbench for counter_wait_wake_engine: directed and random requests,
// predicted responses compared in order against the response channel
// depends on cwwe_pkg and counter_wait_wake_engine
`timescale 1ns / 1ps

module counter_wait_wake_engine_test;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   localparam int ACTION_W     = cwwe_pkg::ACTION_W;
   localparam int CID_W        = cwwe_pkg::CID_W;
   localparam int FIBER_W      = cwwe_pkg::FIBER_W;
   localparam int VAL_W        = cwwe_pkg::VAL_W;
   localparam int STATUS_W     = cwwe_pkg::STATUS_W;
   localparam int NUM_COUNTERS = cwwe_pkg::NUM_COUNTERS_DEF;
   localparam int MAX_WAITERS  = cwwe_pkg::MAX_WAITERS_DEF;
   localparam int NUM_FIBERS   = cwwe_pkg::NUM_FIBERS_DEF;

   typedef struct {
      logic                 woke;
      logic [FIBER_W-1:0]   fiber;
      logic [VAL_W-1:0]     value;
      cwwe_pkg::status_type status;
      logic                 last;
   } wake_result_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [ACTION_W-1:0] req_action;
   logic [CID_W-1:0]    req_counter_id;
   logic [FIBER_W-1:0]  req_fiber_id;
   logic [VAL_W-1:0]    req_target;
   logic [VAL_W-1:0]    req_amount;
   logic                rsp_valid;
   logic                rsp_ready;
   logic                rsp_woke;
   logic [FIBER_W-1:0]  rsp_ready_fiber;
   logic [VAL_W-1:0]    rsp_counter_value;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;

   // predicted block state
   logic [VAL_W-1:0]   count_model [NUM_COUNTERS];
   int                 park_len    [NUM_COUNTERS];
   logic [FIBER_W-1:0] wait_fiber  [NUM_COUNTERS][MAX_WAITERS];
   logic [VAL_W-1:0]   wait_target [NUM_COUNTERS][MAX_WAITERS];

   wake_result_type expected_results[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int fibers_woken = 0;
   int status_seen [4];
   int fail_count = 0;
   int cycle_count = 0;

   counter_wait_wake_engine i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_counter_id    (req_counter_id),
      .req_fiber_id      (req_fiber_id),
      .req_target        (req_target),
      .req_amount        (req_amount),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_woke          (rsp_woke),
      .rsp_ready_fiber   (rsp_ready_fiber),
      .rsp_counter_value (rsp_counter_value),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycle_count,
                  expected_results.size());
         $display("counter_wait_wake_engine test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic void note_mismatch(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endfunction

   function automatic void push_expected(logic woke, logic [FIBER_W-1:0] fiber,
                                         logic [VAL_W-1:0] value,
                                         cwwe_pkg::status_type st, logic last);
      wake_result_type r;
      r.woke = woke;
      r.fiber = fiber;
      r.value = value;
      r.status = st;
      r.last = last;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_wakes(cwwe_pkg::action_type act, logic [CID_W-1:0] cid,
                                         logic [FIBER_W-1:0] fib, logic [VAL_W-1:0] tgt,
                                         logic [VAL_W-1:0] amt);
      logic [VAL_W-1:0]     value;
      logic [VAL_W:0]       sum;
      cwwe_pkg::status_type st;
      int                   kept;
      int                   i;
      logic [FIBER_W-1:0]   woken_fibers[$];
      if (cid >= NUM_COUNTERS) begin
         push_expected(1'b0, '0, '0, cwwe_pkg::ST_OK, 1'b1);
         return;
      end
      value = count_model[cid];
      st = cwwe_pkg::ST_OK;
      case (act)
         cwwe_pkg::ACT_ADD: begin
            sum = {1'b0, value} + {1'b0, amt};
            if (sum > {1'b0, cwwe_pkg::VAL_MAX}) begin
               sum = {1'b0, cwwe_pkg::VAL_MAX};
               st = cwwe_pkg::ST_OVER;
            end
            count_model[cid] = sum[VAL_W-1:0];
            push_expected(1'b0, '0, sum[VAL_W-1:0], st, 1'b1);
         end
         cwwe_pkg::ACT_PARK: begin
            if (fib >= NUM_FIBERS) begin
               push_expected(1'b0, '0, value, cwwe_pkg::ST_OK, 1'b1);
            end else if (value <= tgt) begin
               push_expected(1'b1, fib, value, cwwe_pkg::ST_OK, 1'b1);
            end else if (park_len[cid] >= MAX_WAITERS) begin
               push_expected(1'b0, '0, value, cwwe_pkg::ST_FULL, 1'b1);
            end else begin
               wait_fiber[cid][park_len[cid]] = fib;
               wait_target[cid][park_len[cid]] = tgt;
               park_len[cid]++;
               push_expected(1'b0, '0, value, cwwe_pkg::ST_OK, 1'b1);
            end
         end
         cwwe_pkg::ACT_SIGNAL: begin
            if (value == '0) st = cwwe_pkg::ST_UNDER;
            else value = value - VAL_W'(1);
            count_model[cid] = value;
            kept = 0;
            for (i = 0; i < park_len[cid]; i++) begin
               if (value <= wait_target[cid][i]) begin
                  woken_fibers.push_back(wait_fiber[cid][i]);
               end else begin
                  wait_fiber[cid][kept] = wait_fiber[cid][i];
                  wait_target[cid][kept] = wait_target[cid][i];
                  kept++;
               end
            end
            park_len[cid] = kept;
            if (woken_fibers.size() == 0) begin
               push_expected(1'b0, '0, value, st, 1'b1);
            end else begin
               for (i = 0; i < woken_fibers.size(); i++)
                  push_expected(1'b1, woken_fibers[i], value, st, i == woken_fibers.size() - 1);
            end
         end
         default: begin
            push_expected(1'b0, '0, value, cwwe_pkg::ST_OK, 1'b1);
         end
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      wake_result_type want;
      string           exp_s;
      string           got_s;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         got_s = $sformatf("woke %0b fiber %0d value %0d status %0d last %0b",
                           rsp_woke, rsp_ready_fiber, rsp_counter_value, rsp_status, rsp_last);
         if (expected_results.size() == 0) begin
            note_mismatch({"unexpected response ", got_s});
         end else begin
            want = expected_results.pop_front();
            if (want.woke) fibers_woken++;
            status_seen[want.status]++;
            if (rsp_woke !== want.woke || rsp_ready_fiber !== want.fiber
                || rsp_counter_value !== want.value || rsp_status !== want.status
                || rsp_last !== want.last) begin
               exp_s = $sformatf("woke %0b fiber %0d value %0d status %0d last %0b",
                                 want.woke, want.fiber, want.value, want.status, want.last);
               note_mismatch({"expected ", exp_s, ", got ", got_s});
            end
         end
      end
   end

   task automatic send_request(cwwe_pkg::action_type act, int cid, int fib, int tgt, int amt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_counter_id <= CID_W'(cid);
      req_fiber_id <= FIBER_W'(fib);
      req_target <= VAL_W'(tgt);
      req_amount <= VAL_W'(amt);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_wakes(act, CID_W'(cid), FIBER_W'(fib), VAL_W'(tgt), VAL_W'(amt));
      requests_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_add_limits();
      send_request(cwwe_pkg::ACT_ADD, 0, 0, 0, 0);
      send_request(cwwe_pkg::ACT_ADD, 15, 63, 65535, 65535);
      send_request(cwwe_pkg::ACT_ADD, 15, 0, 0, 1);
      send_request(cwwe_pkg::ACT_ADD, 15, 0, 0, 65535);
   endtask

   task automatic test_park_at_once();
      send_request(cwwe_pkg::ACT_PARK, 15, 63, 65535, 0);
      send_request(cwwe_pkg::ACT_PARK, 0, 0, 0, 65535);
   endtask

   // middle waiter wakes, outer ones stay parked in order
   task automatic test_wake_order();
      send_request(cwwe_pkg::ACT_ADD, 3, 0, 0, 3);
      send_request(cwwe_pkg::ACT_PARK, 3, 10, 1, 0);
      send_request(cwwe_pkg::ACT_PARK, 3, 11, 2, 0);
      send_request(cwwe_pkg::ACT_PARK, 3, 12, 0, 0);
      send_request(cwwe_pkg::ACT_SIGNAL, 3, 0, 0, 0);
   endtask

   // fill a list, overflow it, then wake all of it with one signal
   task automatic test_full_list();
      send_request(cwwe_pkg::ACT_ADD, 5, 0, 0, 1);
      for (int i = 0; i < MAX_WAITERS + 1; i++)
         send_request(cwwe_pkg::ACT_PARK, 5, 20 + i, 0, 0);
      send_request(cwwe_pkg::ACT_SIGNAL, 5, 0, 0, 0);
   endtask

   task automatic test_signal_at_zero();
      send_request(cwwe_pkg::ACT_SIGNAL, 7, 63, 65535, 65535);
   endtask

   task automatic test_unused_action();
      send_request(cwwe_pkg::ACT_NONE, 15, 63, 65535, 65535);
   endtask

   // add, park a few fibers at or below the new count, then signal the count down
   task automatic send_wait_sequence();
      int cid;
      int a;
      int v;
      int t;
      cid = $urandom_range(NUM_COUNTERS - 1);
      a = $urandom_range(1, 5);
      send_request(cwwe_pkg::ACT_ADD, cid, $urandom_range(63), $urandom_range(65535), a);
      v = count_model[cid];
      repeat ($urandom_range(1, 5)) begin
         t = v - $urandom_range(0, a + 1);
         if (t < 0) t = 0;
         send_request(cwwe_pkg::ACT_PARK, cid, $urandom_range(63), t, $urandom_range(65535));
      end
      repeat (a + $urandom_range(0, 1))
         send_request(cwwe_pkg::ACT_SIGNAL, cid, $urandom_range(63), $urandom_range(65535),
                      $urandom_range(65535));
   endtask

   task automatic send_noise();
      int amt;
      int tgt;
      amt = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(7);
      tgt = ($urandom_range(1) == 0) ? $urandom_range(65535) : $urandom_range(7);
      send_request(cwwe_pkg::action_type'(ACTION_W'($urandom_range(3))),
                   $urandom_range(NUM_COUNTERS - 1), $urandom_range(63), tgt, amt);
   endtask

   task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
      int stop_at;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      stop_at = requests_sent + count;
      while (requests_sent < stop_at) begin
         if ($urandom_range(99) < 75) send_wait_sequence();
         else send_noise();
      end
      wait_for_results();
   endtask

   initial begin
      for (int c = 0; c < NUM_COUNTERS; c++) begin
         count_model[c] = '0;
         park_len[c] = 0;
      end
      for (int s = 0; s < 4; s++) status_seen[s] = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= cwwe_pkg::ACT_ADD;
      req_counter_id <= '0;
      req_fiber_id <= '0;
      req_target <= '0;
      req_amount <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_add_limits();
      test_park_at_once();
      test_wake_order();
      test_full_list();
      test_signal_at_zero();
      test_unused_action();
      wait_for_results();

      test_random_traffic(34, 0, 0);
      test_random_traffic(34, 69, 0);
      test_random_traffic(34, 0, 69);
      test_random_traffic(34, 36, 36);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d requests, checked %0d responses, %0d fibers woken", requests_sent,
               results_checked, fibers_woken);
      $display("status ok %0d, list full %0d, underflow %0d, saturated %0d, mismatches %0d",
               status_seen[cwwe_pkg::ST_OK], status_seen[cwwe_pkg::ST_FULL],
               status_seen[cwwe_pkg::ST_UNDER], status_seen[cwwe_pkg::ST_OVER], fail_count);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("counter_wait_wake_engine test passed");
      end else begin
         $display("counter_wait_wake_engine test failed");
      end
      $finish;
   end

endmodule
